@@ rtl/pause_anchor_tracker_defines.svh @@
// assertion macros for the pause anchor tracker
// used by the top level; expects clk and arst_n in the including scope
`ifndef PAUSE_ANCHOR_TRACKER_DEFINES_SVH
`define PAUSE_ANCHOR_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PAT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PAT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PAT_ASSERT_IMP(lbl, ante, cons, msg)
`define PAT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/pat_pkg.sv @@
// shared types and constants of the pause anchor tracker
// no dependencies
package pat_pkg;

	localparam int REG_W             = 24;
	localparam int LEN_W             = 16;
	localparam int MODE_W            = 2;
	localparam int APB_ADDR_W        = 4;
	localparam int APB_DATA_W        = 32;
	localparam int MAX_ANCHORS_DEF   = 512;
	localparam int POSITION_BITS_DEF = 24;

	localparam logic [MODE_W-1:0] MODE_BLOCK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SNAP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	localparam logic [1:0] REG_ANCHOR_SLACK = 2'd0;
	localparam logic [1:0] REG_SNAP_SLACK   = 2'd1;
	localparam logic [1:0] REG_RESUME_QUIET = 2'd2;
	localparam logic [1:0] REG_CEILING      = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} st_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LEN_W-1:0]  block_length;
		logic              loud;
		logic [REG_W-1:0]  query_position;
	} req_t;

	typedef struct packed {
		logic [REG_W-1:0] snapped_position;
		logic [LEN_W-1:0] taken_length;
		logic             clamped;
		logic             anchor_added;
	} rsp_t;

	typedef struct packed {
		logic init;
		logic cmp;
	} snap_ctl_t;

endpackage

@@ rtl/pat_anchor_mem.sv @@
// anchor store: one write port, one read port with registered data
// no package dependencies
module pat_anchor_mem #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/pat_snap_unit.sv @@
// nearest-anchor search for snap requests, one anchor per cycle
// depends on pat_pkg
module pat_snap_unit #(
	parameter int POSITION_BITS = pat_pkg::POSITION_BITS_DEF
) (
	input  logic                        clk,
	input  pat_pkg::snap_ctl_t          ctl,
	input  logic [pat_pkg::REG_W-1:0]   query,
	input  logic [pat_pkg::REG_W-1:0]   snap_slack,
	input  logic [POSITION_BITS-1:0]    rd_data,
	input  logic [POSITION_BITS-1:0]    turn_length,
	output logic [pat_pkg::REG_W-1:0]   snapped
);

	localparam int W = (POSITION_BITS > pat_pkg::REG_W) ? POSITION_BITS : pat_pkg::REG_W;

	logic [W-1:0] query_q;
	logic [W-1:0] best_q;
	logic [W:0]   gap_q;

	logic [W-1:0] q_w;
	logic [W:0]   slack_p1;
	logic [W-1:0] a_w;
	logic [W:0]   a_diff;
	logic [W-1:0] a_gap;
	logic [W-1:0] t_w;
	logic [W:0]   t_diff;
	logic [W-1:0] t_gap;
	logic [W-1:0] result;

	always_comb begin
		q_w      = W'(query);
		slack_p1 = {1'b0, W'(snap_slack)} + (W+1)'(1);
		a_w      = W'(rd_data);
		a_diff   = {1'b0, a_w} - {1'b0, query_q};
		a_gap    = a_diff[W] ? (query_q - a_w) : a_diff[W-1:0];
		t_w      = W'(turn_length);
		t_diff   = {1'b0, t_w} - {1'b0, query_q};
		t_gap    = t_diff[W] ? (query_q - t_w) : t_diff[W-1:0];
		// turn end wins only when strictly nearer
		result   = ({1'b0, t_gap} < gap_q) ? t_w : best_q;
		snapped  = result[pat_pkg::REG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			query_q <= q_w;
			// anchor 0 always sits at sample zero, its gap is the query itself
			if ({1'b0, q_w} < slack_p1) begin
				best_q <= '0;
				gap_q  <= {1'b0, q_w};
			end else begin
				best_q <= q_w;
				gap_q  <= slack_p1;
			end
		end else if (ctl.cmp && ({1'b0, a_gap} < gap_q)) begin
			best_q <= a_w;
			gap_q  <= {1'b0, a_gap};
		end
	end

endmodule

@@ rtl/pause_anchor_tracker.sv @@
// top level of the pause anchor tracker: control, turn state, config registers
// depends on pat_pkg, pat_anchor_mem, pat_snap_unit, pause_anchor_tracker_defines.svh
//
// usage
//   request channel (req_valid, req_stall, req): one request per handshake,
//   mode selects block event, snap query or restart. A request is taken at a
//   rising edge with req_valid high and req_stall low.
//   response channel (rsp_valid, rsp_stall, rsp): exactly one response per
//   request, in order. The response sits in an output register and holds
//   while rsp_stall is high.
//   config: APB write/read of four 24-bit registers at byte addresses 0..12.
// sequencing
//   block events, restarts and unknown modes: the request is taken, then the
//   turn state is updated and the response registered in the apply state.
//   snap queries: a scan state lies between take and apply; the single read
//   port of the anchor memory walks the stored anchors one per cycle.
//   a request is taken only while the sequencer is idle; the finishing cycle
//   waits while the output register is full and stalled.
// reset
//   arst_n clears turn length, quiet run and the registers, sets one anchor
//   at sample zero. Anchor 0 is implied zero, so no memory clearing pass.
`include "pause_anchor_tracker_defines.svh"
module pause_anchor_tracker #(
	parameter int MAX_ANCHORS   = pat_pkg::MAX_ANCHORS_DEF,
	parameter int POSITION_BITS = pat_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_stall,
	input  pat_pkg::req_t                    req,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output pat_pkg::rsp_t                    rsp,
	// APB config port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pat_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [pat_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pat_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	localparam int AW = $clog2(MAX_ANCHORS);
	localparam int CW = $clog2(MAX_ANCHORS + 1);
	localparam int PB = POSITION_BITS;
	localparam int W  = (PB > pat_pkg::REG_W) ? PB : pat_pkg::REG_W;
	localparam logic [W-1:0] POS_MASK_W = W'((64'd1 << PB) - 64'd1);

	// config registers
	logic [pat_pkg::REG_W-1:0] anchor_slack_q;
	logic [pat_pkg::REG_W-1:0] snap_slack_q;
	logic [pat_pkg::REG_W-1:0] resume_quiet_q;
	logic [pat_pkg::REG_W-1:0] ceiling_q;

	// turn state
	logic [PB-1:0] turn_q;
	logic [PB-1:0] quiet_q;
	logic          was_quiet_q;
	logic [CW-1:0] count_q;
	logic [PB-1:0] last_q;      // copy of the newest stored anchor

	// sequencer
	pat_pkg::st_t  state_q;
	pat_pkg::st_t  state_nxt;
	pat_pkg::req_t req_q;
	logic [PB-1:0] rem_q;       // room left below the limit
	logic [PB-1:0] dist_q;      // distance of the block start to the last anchor
	logic [CW-1:0] scan_idx_q;
	logic          rd_vld_s1;

	// output register
	pat_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	logic                  req_acc;
	logic                  rsp_free;
	logic                  cfg_we;
	logic                  rd_en;
	logic                  mem_we;
	logic                  apply_go;
	logic [PB-1:0]         rd_data;
	logic [pat_pkg::REG_W-1:0] snapped;
	pat_pkg::snap_ctl_t    snap_ctl;

	// accept-time terms
	logic [W-1:0]  ceil_w;
	logic [W-1:0]  limit_w;
	logic [PB-1:0] limit;
	logic [PB-1:0] rem_n;
	logic [PB-1:0] dist_n;

	// apply-time terms
	logic [PB-1:0] len_pb;
	logic [PB-1:0] taken;
	logic          clamped;
	logic [PB-1:0] turn_nxt;
	logic [PB:0]   quiet_sum;
	logic [PB-1:0] quiet_nxt;
	logic          quiet_ok;
	logic          slack_ok;
	logic          room;
	logic          try_store;
	logic          store;
	pat_pkg::rsp_t rsp_n;

	assign req_acc  = req_valid && !req_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// config write and readback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_slack_q <= '0;
			snap_slack_q   <= '0;
			resume_quiet_q <= '0;
			ceiling_q      <= '0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				pat_pkg::REG_ANCHOR_SLACK: anchor_slack_q <= pwdata[pat_pkg::REG_W-1:0];
				pat_pkg::REG_SNAP_SLACK:   snap_slack_q   <= pwdata[pat_pkg::REG_W-1:0];
				pat_pkg::REG_RESUME_QUIET: resume_quiet_q <= pwdata[pat_pkg::REG_W-1:0];
				pat_pkg::REG_CEILING:      ceiling_q      <= pwdata[pat_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pat_pkg::REG_ANCHOR_SLACK: prdata = pat_pkg::APB_DATA_W'(anchor_slack_q);
			pat_pkg::REG_SNAP_SLACK:   prdata = pat_pkg::APB_DATA_W'(snap_slack_q);
			pat_pkg::REG_RESUME_QUIET: prdata = pat_pkg::APB_DATA_W'(resume_quiet_q);
			pat_pkg::REG_CEILING:      prdata = pat_pkg::APB_DATA_W'(ceiling_q);
			default:                   prdata = '0;
		endcase
	end

	// limit and distances from the current turn, latched with the request
	always_comb begin
		ceil_w  = W'(ceiling_q);
		// zero ceiling means the turn only saturates at the position range
		limit_w = ((ceil_w == '0) || (ceil_w > POS_MASK_W)) ? POS_MASK_W : ceil_w;
		limit   = limit_w[PB-1:0];
		rem_n   = (turn_q >= limit) ? '0 : (limit - turn_q);
		dist_n  = (last_q >= turn_q) ? (last_q - turn_q) : (turn_q - last_q);
	end

	// block event update, done in the apply cycle
	always_comb begin
		len_pb    = PB'(req_q.block_length);
		taken     = (len_pb <= rem_q) ? len_pb : rem_q;
		clamped   = (taken < len_pb);
		turn_nxt  = turn_q + taken;
		quiet_sum = {1'b0, quiet_q} + {1'b0, taken};
		quiet_nxt = quiet_sum[PB] ? {PB{1'b1}} : quiet_sum[PB-1:0];
		quiet_ok  = (W'(quiet_q) >= W'(resume_quiet_q));
		slack_ok  = (W'(dist_q) > W'(anchor_slack_q));
		room      = (count_q < CW'(MAX_ANCHORS));
		// resume after a long quiet run, or speech stopping
		try_store = req_q.loud ? (was_quiet_q && quiet_ok) : !was_quiet_q;
		store     = try_store && slack_ok && room;
	end

	always_comb begin
		rsp_n = '0;
		case (req_q.mode)
			pat_pkg::MODE_BLOCK: begin
				rsp_n.taken_length = taken[pat_pkg::LEN_W-1:0];
				rsp_n.clamped      = clamped;
				rsp_n.anchor_added = store;
			end
			pat_pkg::MODE_SNAP: begin
				rsp_n.snapped_position = snapped;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pat_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_nxt = (req.mode == pat_pkg::MODE_SNAP) ? pat_pkg::ST_SCAN
					                                             : pat_pkg::ST_APPLY;
				end
			end
			pat_pkg::ST_SCAN: begin
				if (scan_idx_q >= count_q) begin
					state_nxt = pat_pkg::ST_APPLY;
				end
			end
			pat_pkg::ST_APPLY: begin
				if (rsp_free) begin
					state_nxt = pat_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pat_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_stall     = (state_q != pat_pkg::ST_IDLE);
		rd_en         = (state_q == pat_pkg::ST_SCAN) && (scan_idx_q < count_q);
		apply_go      = (state_q == pat_pkg::ST_APPLY) && rsp_free;
		mem_we        = apply_go && (req_q.mode == pat_pkg::MODE_BLOCK) && store;
		snap_ctl.init = req_acc && (req.mode == pat_pkg::MODE_SNAP);
		snap_ctl.cmp  = rd_vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pat_pkg::ST_IDLE;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
			turn_q      <= '0;
			quiet_q     <= '0;
			was_quiet_q <= 1'b1;
			count_q     <= CW'(1);
			last_q      <= '0;
			scan_idx_q  <= '0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= rd_en;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (req_acc) begin
				// anchor 0 needs no read
				scan_idx_q <= CW'(1);
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
				case (req_q.mode)
					pat_pkg::MODE_BLOCK: begin
						turn_q <= turn_nxt;
						if (req_q.loud) begin
							quiet_q     <= '0;
							was_quiet_q <= 1'b0;
						end else begin
							quiet_q     <= quiet_nxt;
							was_quiet_q <= 1'b1;
						end
						if (store) begin
							count_q <= count_q + CW'(1);
							last_q  <= turn_q;
						end
					end
					pat_pkg::MODE_RESTART: begin
						turn_q      <= '0;
						quiet_q     <= '0;
						was_quiet_q <= 1'b1;
						count_q     <= CW'(1);
						last_q      <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q  <= req;
			rem_q  <= rem_n;
			dist_q <= dist_n;
		end
		if (apply_go) begin
			rsp_q <= rsp_n;
		end
	end

	pat_anchor_mem #(
		.DEPTH(MAX_ANCHORS),
		.WIDTH(PB)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(turn_q),
		.re   (rd_en),
		.raddr(scan_idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	pat_snap_unit #(
		.POSITION_BITS(PB)
	) u_snap (
		.clk        (clk),
		.ctl        (snap_ctl),
		.query      (req.query_position),
		.snap_slack (snap_slack_q),
		.rd_data    (rd_data),
		.turn_length(turn_q),
		.snapped    (snapped)
	);

	`PAT_ASSERT_IMP(a_count_range, 1'b1, (count_q != '0) && (count_q <= CW'(MAX_ANCHORS)), "anchor count out of range")
	`PAT_ASSERT_IMP(a_write_not_zero, mem_we, (count_q != '0) && (count_q < CW'(MAX_ANCHORS)), "anchor write outside the free entries")
	`PAT_ASSERT_IMP(a_read_in_fill, rd_en, (scan_idx_q != '0) && (scan_idx_q < count_q), "snap read of an unfilled entry")
	`PAT_ASSERT_NXT(a_turn_only_apply, state_q != pat_pkg::ST_APPLY, $stable(turn_q), "turn length changed outside apply")
	`PAT_ASSERT_IMP(a_no_scan_into_apply, state_q == pat_pkg::ST_APPLY, !rd_en && !snap_ctl.init, "snap search busy during apply")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// testbench of the pause anchor tracker: directed and random requests, each response
// checked against an in-bench tracker model; needs pat_pkg and pause_anchor_tracker
module tb_top;
	import pat_pkg::*;

	localparam int MAX_ANCH = MAX_ANCHORS_DEF;
	localparam logic [REG_W-1:0] POS_MAX = {REG_W{1'b1}};
	// mode code the block must ignore
	localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;
	// long receiver hold-off, in cycles
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1_000_000;
	// quiet cycles after the last response before the verdict
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PER_SLICE = 217;

	// block ports; the inputs are driven to known values from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// register mirror
	logic [REG_W-1:0] cfg_anchor_slack = '0;
	logic [REG_W-1:0] cfg_snap_slack = '0;
	logic [REG_W-1:0] cfg_resume_quiet = '0;
	logic [REG_W-1:0] cfg_ceiling = '0;

	// tracker model state
	logic [REG_W-1:0] trk_turn;
	logic [REG_W-1:0] trk_quiet_run;
	logic trk_was_quiet;
	logic [REG_W-1:0] trk_anchors [MAX_ANCH];
	int unsigned trk_count;

	// responses owed by the block, oldest first
	rsp_t due_results[$];
	int mismatches = 0;

	// idling knobs, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct = 0;
	// set by a test to start one long receiver hold-off
	bit hold_pending = 1'b0;
	// loud flag of the last random block, to build speech/quiet runs
	bit rnd_loud = 1'b0;
	int unsigned cycles = 0;

	pause_anchor_tracker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------- model

	function automatic logic [REG_W-1:0] span(input logic [REG_W-1:0] a, input logic [REG_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// restart: empty turn, only the anchor at sample zero survives
	function automatic void clear_turn();
		trk_turn = '0;
		trk_quiet_run = '0;
		trk_was_quiet = 1'b1;
		trk_anchors[0] = '0;
		trk_count = 1;
	endfunction

	// store an anchor unless too close to the last one or the store is full
	function automatic logic add_anchor(input logic [REG_W-1:0] at);
		if (span(trk_anchors[trk_count - 1], at) <= cfg_anchor_slack)
			return 1'b0;
		if (trk_count >= MAX_ANCH)
			return 1'b0;
		trk_anchors[trk_count] = at;
		trk_count++;
		return 1'b1;
	endfunction

	// advance the model by one request and return the response it owes
	function automatic rsp_t track_request(input req_t r);
		rsp_t o;
		int unsigned lim;
		int unsigned take;
		int unsigned sum;
		int unsigned gap;
		int unsigned best_gap;
		logic [REG_W-1:0] start;
		logic [REG_W-1:0] best;
		int unsigned i;
		o = '0;
		case (r.mode)
			MODE_BLOCK: begin
				// zero ceiling means the turn only stops at the position range
				lim = (cfg_ceiling != 0) ? cfg_ceiling : POS_MAX;
				start = trk_turn;
				take = r.block_length;
				if (trk_turn >= lim)
					take = 0;
				else if (trk_turn + take > lim)
					take = lim - trk_turn;
				o.taken_length = take[LEN_W-1:0];
				o.clamped = (take < r.block_length);
				trk_turn = trk_turn + take[REG_W-1:0];
				if (r.loud) begin
					// speech resumes after a long enough quiet run
					if (trk_was_quiet && trk_quiet_run >= cfg_resume_quiet)
						o.anchor_added = add_anchor(start);
					trk_quiet_run = '0;
					trk_was_quiet = 1'b0;
				end else begin
					// speech stops
					if (!trk_was_quiet)
						o.anchor_added = add_anchor(start);
					sum = trk_quiet_run + take;
					trk_quiet_run = (sum > POS_MAX) ? POS_MAX : sum[REG_W-1:0];
					trk_was_quiet = 1'b1;
				end
			end
			MODE_SNAP: begin
				best = r.query_position;
				best_gap = cfg_snap_slack + 1;
				// strict compare: on a tie the earliest anchor stays
				for (i = 0; i < trk_count; i++) begin
					gap = span(trk_anchors[i], r.query_position);
					if (gap < best_gap) begin
						best = trk_anchors[i];
						best_gap = gap;
					end
				end
				// turn end only wins when strictly nearer
				if (span(trk_turn, r.query_position) < best_gap)
					best = trk_turn;
				o.snapped_position = best;
			end
			MODE_RESTART: begin
				clear_turn();
			end
			default: begin
				// unknown mode leaves everything alone and answers zeros
			end
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			note_mismatch(what, want, got);
	endfunction

	// every accepted response against the oldest owed one
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				note_mismatch("response with no request outstanding", '0, rsp.snapped_position);
			end else begin
				want = due_results.pop_front();
				check_field("snapped_position", want.snapped_position, rsp.snapped_position);
				check_field("taken_length", want.taken_length, rsp.taken_length);
				check_field("clamped", want.clamped, rsp.clamped);
				check_field("anchor_added", want.anchor_added, rsp.anchor_added);
			end
		end
	end

	// receiver: random stall, or one long hold-off counted here
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	function automatic req_t request_of(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] len,
			input logic ld, input logic [REG_W-1:0] q);
		req_t r;
		r.mode = m;
		r.block_length = len;
		r.loud = ld;
		r.query_position = q;
		return r;
	endfunction

	// offer one request, with a random gap first; predict at the accepting edge
	task automatic send_request(input req_t r);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		due_results.push_back(track_request(r));
	endtask

	// stop offering until every owed response is in
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	// write one register, then read it back with psel held through
	task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_DATA_W-REG_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ANCHOR_SLACK: cfg_anchor_slack = val;
			REG_SNAP_SLACK:   cfg_snap_slack = val;
			REG_RESUME_QUIET: cfg_resume_quiet = val;
			REG_CEILING:      cfg_ceiling = val;
			default: ;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register readback", {{(APB_DATA_W-REG_W){1'b0}}, val}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// only touched once the block has answered everything
	task automatic set_config(input logic [REG_W-1:0] a_slack, input logic [REG_W-1:0] s_slack,
			input logic [REG_W-1:0] r_quiet, input logic [REG_W-1:0] ceil);
		drain_results();
		write_reg(REG_ANCHOR_SLACK, a_slack);
		write_reg(REG_SNAP_SLACK, s_slack);
		write_reg(REG_RESUME_QUIET, r_quiet);
		write_reg(REG_CEILING, ceil);
	endtask

	function automatic logic [REG_W-1:0] pick_setting(input int unsigned typical);
		int unsigned sel;
		logic [31:0] raw;
		sel = $urandom_range(9);
		raw = $urandom_range(typical);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return POS_MAX;
		return raw[REG_W-1:0];
	endfunction

	// mostly speech/quiet runs and queries near stored anchors, some noise
	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		int unsigned sub;
		int unsigned idx;
		logic [31:0] raw;
		logic [REG_W-1:0] base;
		logic [REG_W-1:0] off;
		raw = $urandom;
		r = request_of(MODE_BLOCK, raw[LEN_W-1:0], raw[LEN_W], raw[REG_W-1:0]);
		pick = $urandom_range(99);
		sub = $urandom_range(9);
		if (pick < 65) begin
			if (sub == 0)
				r.block_length = '0;
			else if (sub == 1)
				r.block_length = '1;
			else if (sub > 2)
				r.block_length = LEN_W'($urandom_range(1, 400));
			if ($urandom_range(99) < 55)
				rnd_loud = !rnd_loud;
			r.loud = rnd_loud;
		end else if (pick < 85) begin
			r.mode = MODE_SNAP;
			off = REG_W'($urandom_range(64));
			idx = $urandom_range(trk_count - 1);
			if (sub < 4)
				base = trk_anchors[idx];
			else if (sub < 6)
				base = trk_turn;
			else
				base = REG_W'($urandom_range(trk_turn + 100));
			if (sub == 9)
				r.query_position = raw[REG_W-1:0];
			else if ($urandom_range(1) == 1)
				r.query_position = base + off;
			else
				r.query_position = base - off;
		end else if (pick < 91) begin
			r.mode = MODE_RESTART;
		end else if (pick < 95) begin
			r.mode = MODE_UNKNOWN;
		end else begin
			// noise: any mode with whatever fields came up
			r.mode = raw[REG_W+1:REG_W];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- tests

	// reset registers: snaps on the empty turn, ignored mode, first blocks
	task automatic test_reset_state();
		send_idle_pct = 16;
		stall_pct = 70;
		send_request(request_of(MODE_SNAP, '0, 1'b0, '0));
		send_request(request_of(MODE_SNAP, '1, 1'b1, POS_MAX));
		send_request(request_of(MODE_UNKNOWN, '1, 1'b1, POS_MAX));
		send_request(request_of(MODE_BLOCK, '0, 1'b1, '0));
		send_request(request_of(MODE_BLOCK, 16'd100, 1'b1, POS_MAX));
		send_request(request_of(MODE_BLOCK, '1, 1'b0, '0));
		send_request(request_of(MODE_BLOCK, 16'd30, 1'b1, '0));
		send_request(request_of(MODE_RESTART, '1, 1'b1, POS_MAX));
	endtask

	// resume threshold, anchor spacing, snap ties and the turn end rule
	task automatic test_spacing_and_snap();
		set_config(24'd40, 24'd60, 24'd200, '0);
		// anchors land at 300, 550, 600, 650; the one at 670 is too close
		send_request(request_of(MODE_BLOCK, 16'd300, 1'b1, '0));
		send_request(request_of(MODE_BLOCK, 16'd250, 1'b0, '0));
		send_request(request_of(MODE_BLOCK, 16'd50, 1'b1, '0));
		send_request(request_of(MODE_BLOCK, 16'd30, 1'b0, '0));
		send_request(request_of(MODE_BLOCK, 16'd20, 1'b1, '0));
		send_request(request_of(MODE_BLOCK, 16'd10, 1'b0, '0));
		send_request(request_of(MODE_BLOCK, 16'd10, 1'b1, '0));
		send_request(request_of(MODE_BLOCK, 16'd6, 1'b0, '0));
		// tie between two anchors, tie with the turn end, turn end nearer, nothing near
		send_request(request_of(MODE_SNAP, '0, 1'b0, 24'd575));
		send_request(request_of(MODE_SNAP, '0, 1'b0, 24'd663));
		send_request(request_of(MODE_SNAP, '0, 1'b0, 24'd674));
		send_request(request_of(MODE_SNAP, '0, 1'b0, 24'd100000));
	endtask

	// ceiling clamp, ceiling dropped under the turn, widest spacing
	task automatic test_ceiling();
		set_config(POS_MAX, '0, '0, 24'd1000);
		send_request(request_of(MODE_RESTART, '0, 1'b0, '0));
		send_request(request_of(MODE_BLOCK, 16'd600, 1'b1, '0));
		send_request(request_of(MODE_BLOCK, 16'd600, 1'b0, '0));
		send_request(request_of(MODE_BLOCK, 16'd5, 1'b1, '0));
		drain_results();
		write_reg(REG_CEILING, 24'd500);
		send_request(request_of(MODE_BLOCK, '0, 1'b0, '0));
		send_request(request_of(MODE_BLOCK, 16'd10, 1'b1, '0));
		drain_results();
		write_reg(REG_CEILING, POS_MAX);
		send_request(request_of(MODE_BLOCK, '1, 1'b0, '0));
	endtask

	// no ceiling: quiet blocks run the turn and the quiet run into saturation
	task automatic test_saturation();
		int k;
		send_idle_pct = 0;
		stall_pct = 0;
		set_config('0, POS_MAX, POS_MAX, '0);
		send_request(request_of(MODE_RESTART, '0, 1'b0, '0));
		for (k = 0; k < 258; k++)
			send_request(request_of(MODE_BLOCK, '1, 1'b0, '0));
		// saturated quiet run meets the largest resume threshold
		send_request(request_of(MODE_BLOCK, 16'd1, 1'b1, '0));
		send_request(request_of(MODE_SNAP, '0, 1'b0, POS_MAX));
		send_request(request_of(MODE_SNAP, '0, 1'b0, 24'd1));
	endtask

	// fill the anchor store; the receiver holds off so the block backs up
	task automatic test_store_full();
		int k;
		logic loud_now;
		send_idle_pct = 0;
		stall_pct = 16;
		set_config('0, 24'd100, '0, '0);
		send_request(request_of(MODE_RESTART, '0, 1'b0, '0));
		hold_pending = 1'b1;
		loud_now = 1'b1;
		for (k = 0; k < MAX_ANCH + 20; k++) begin
			send_request(request_of(MODE_BLOCK, LEN_W'($urandom_range(1, 64)), loud_now, '0));
			loud_now = !loud_now;
			if (k % 200 == 100)
				send_request(request_of(MODE_SNAP, '0, 1'b0, trk_turn >> 1));
		end
		send_request(request_of(MODE_SNAP, '0, 1'b0, trk_turn));
		send_request(request_of(MODE_SNAP, '0, 1'b0, trk_anchors[MAX_ANCH - 1] + 24'd3));
	endtask

	// three slices with different idling, fresh registers and a mid-slice pause
	task automatic test_random();
		int slice;
		int n;
		for (slice = 0; slice < 3; slice++) begin
			send_idle_pct = (slice == 0) ? 16 : (slice == 1) ? 70 : 0;
			stall_pct = (slice == 0) ? 70 : (slice == 1) ? 16 : 0;
			set_config(pick_setting(200), pick_setting(3000), pick_setting(2000),
				pick_setting(20000));
			for (n = 0; n < RANDOM_PER_SLICE; n++) begin
				// sender pause until all responses are in
				if (n == RANDOM_PER_SLICE / 2)
					drain_results();
				send_request(random_request());
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_turn();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_spacing_and_snap();
		test_ceiling();
		test_saturation();
		test_store_full();
		test_random();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
